// ===== design/fixed_point_escape_time_iterator_defines.svh =====
// ---------------------------------------------------------------------------
// fixed_point_escape_time_iterator_defines
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef FIXED_POINT_ESCAPE_TIME_ITERATOR_DEFINES_SVH
`define FIXED_POINT_ESCAPE_TIME_ITERATOR_DEFINES_SVH

// same-cycle implication
`define FPET_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fpet_pkg.sv =====
// ---------------------------------------------------------------------------
// fpet_pkg
// types, constants and codes of the fixed point escape time iterator
// ---------------------------------------------------------------------------
package fpet_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int WORD_BITS     = 32;
    localparam int IN_BITS       = 32;
    localparam int CNT_BITS      = 12;
    localparam int MODE_BITS     = 3;
    localparam int POW_BITS      = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int SAVE_BITS     = CNT_BITS + 1;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t ESCAPE_LIMIT = word_t'(64'sd4 <<< FRAC_BITS);
    localparam word_t PHOENIX_COEF = word_t'(-(64'sd1 <<< (FRAC_BITS - 1)));

    localparam logic [MODE_BITS-1:0] MODE_RESET  = '0;
    localparam logic [CNT_BITS-1:0]  LIMIT_RESET = CNT_BITS'(256);
    localparam logic [POW_BITS-1:0]  POWER_RESET = POW_BITS'(3);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PLAIN,
        MODE_SHIP,
        MODE_TRICORN,
        MODE_MULTI,
        MODE_PHOENIX
    } mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODE,
        REG_LIMIT,
        REG_POWER
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RR,
        ST_II,
        ST_X,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_P1,
        ST_P2,
        ST_UPD,
        ST_CYC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [CNT_BITS-1:0]  limit;
        logic [POW_BITS-1:0]  power;
    } cfg_t;

    typedef struct packed {
        logic                done;
        logic [CNT_BITS-1:0] count;
    } result_t;

endpackage

// ===== design/fpet_mul.sv =====
// ---------------------------------------------------------------------------
// fpet_mul
// shared fixed point multiplier, floor(a*b / 2^FRAC_BITS) with wrap
// ---------------------------------------------------------------------------
module fpet_mul
(
    input  fpet_pkg::word_t a,
    input  fpet_pkg::word_t b,
    output fpet_pkg::word_t p
);

    logic signed [2*fpet_pkg::WORD_BITS-1:0] full;

    assign full = (2*fpet_pkg::WORD_BITS)'(a) * (2*fpet_pkg::WORD_BITS)'(b);
    assign p    = fpet_pkg::word_t'(full[fpet_pkg::FRAC_BITS +: fpet_pkg::WORD_BITS]);

endmodule

// ===== design/fpet_core.sv =====
// ---------------------------------------------------------------------------
// fpet_core
// iteration sequencer and state registers around the shared multiplier
// ---------------------------------------------------------------------------
module fpet_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [fpet_pkg::IN_BITS-1:0] start_re,
    input  logic signed [fpet_pkg::IN_BITS-1:0] start_im,
    input  logic signed [fpet_pkg::IN_BITS-1:0] const_re,
    input  logic signed [fpet_pkg::IN_BITS-1:0] const_im,
    input  fpet_pkg::cfg_t                    cfg,
    input  logic                              out_free,
    output logic                              busy,
    output fpet_pkg::result_t                 result
);

    fpet_pkg::state_t state_reg, state_next;
    fpet_pkg::mode_t  mode_reg, mode_next;

    fpet_pkg::word_t zr_reg, zr_next, zi_reg, zi_next;
    fpet_pkg::word_t cr_reg, cr_next, ci_reg, ci_next;
    fpet_pkg::word_t pr_reg, pr_next, pi_reg, pi_next;
    fpet_pkg::word_t sr_reg, sr_next, si_reg, si_next;
    fpet_pkg::word_t spr_reg, spr_next, spi_reg, spi_next;
    fpet_pkg::word_t rr_reg, rr_next, ii_reg, ii_next, xx_reg, xx_next;
    fpet_pkg::word_t wr_reg, wr_next, wi_reg, wi_next;
    fpet_pkg::word_t ta_reg, ta_next, tb_reg, tb_next, tc_reg, tc_next;

    logic [fpet_pkg::CNT_BITS-1:0]  i_reg, i_next;
    logic [fpet_pkg::CNT_BITS-1:0]  limit_reg, limit_next;
    logic [fpet_pkg::CNT_BITS-1:0]  res_reg, res_next;
    logic [fpet_pkg::SAVE_BITS-1:0] save_reg, save_next;
    logic [fpet_pkg::POW_BITS-1:0]  k_reg, k_next;
    logic [fpet_pkg::POW_BITS-1:0]  power_reg, power_next;

    fpet_pkg::word_t mul_a, mul_b, prod;
    fpet_pkg::word_t mag_sum, xm, nr, ni;
    logic [fpet_pkg::CNT_BITS:0]    i_inc;
    logic [fpet_pkg::POW_BITS:0]    k_inc;
    logic                           match;

    fpet_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .p (prod)
    );

    always_comb
    begin
        unique case (state_reg)
            fpet_pkg::ST_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            fpet_pkg::ST_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            fpet_pkg::ST_X:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            fpet_pkg::ST_M1:
            begin
                mul_a = wr_reg;
                mul_b = zr_reg;
            end
            fpet_pkg::ST_M2:
            begin
                mul_a = wi_reg;
                mul_b = zi_reg;
            end
            fpet_pkg::ST_M3:
            begin
                mul_a = wr_reg;
                mul_b = zi_reg;
            end
            fpet_pkg::ST_M4:
            begin
                mul_a = wi_reg;
                mul_b = zr_reg;
            end
            fpet_pkg::ST_P1:
            begin
                mul_a = fpet_pkg::PHOENIX_COEF;
                mul_b = pr_reg;
            end
            fpet_pkg::ST_P2:
            begin
                mul_a = fpet_pkg::PHOENIX_COEF;
                mul_b = pi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
        endcase
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        pr_next    = pr_reg;
        pi_next    = pi_reg;
        sr_next    = sr_reg;
        si_next    = si_reg;
        spr_next   = spr_reg;
        spi_next   = spi_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        xx_next    = xx_reg;
        wr_next    = wr_reg;
        wi_next    = wi_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        tc_next    = tc_reg;
        i_next     = i_reg;
        limit_next = limit_reg;
        res_next   = res_reg;
        save_next  = save_reg;
        k_next     = k_reg;
        power_next = power_reg;

        mag_sum = rr_reg + ii_reg;
        i_inc   = {1'b0, i_reg} + 1'b1;
        k_inc   = {1'b0, k_reg} + 1'b1;
        match   = (zr_reg == sr_reg) && (zi_reg == si_reg)
                  && (pr_reg == spr_reg) && (pi_reg == spi_reg);

        xm = xx_reg;
        if (mode_reg == fpet_pkg::MODE_SHIP && xx_reg < 0)
        begin
            xm = -xx_reg;
        end
        else if (mode_reg == fpet_pkg::MODE_TRICORN)
        begin
            xm = -xx_reg;
        end
        nr = rr_reg - ii_reg + cr_reg;
        ni = xm + xm + ci_reg;

        unique case (state_reg)
            fpet_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    zr_next    = fpet_pkg::word_t'(start_re);
                    zi_next    = fpet_pkg::word_t'(start_im);
                    cr_next    = fpet_pkg::word_t'(const_re);
                    ci_next    = fpet_pkg::word_t'(const_im);
                    pr_next    = '0;
                    pi_next    = '0;
                    sr_next    = fpet_pkg::word_t'(start_re);
                    si_next    = fpet_pkg::word_t'(start_im);
                    spr_next   = '0;
                    spi_next   = '0;
                    i_next     = '0;
                    save_next  = fpet_pkg::SAVE_BITS'(1);
                    limit_next = cfg.limit;
                    power_next = cfg.power;
                    mode_next  = (cfg.mode > fpet_pkg::MODE_PHOENIX) ? fpet_pkg::MODE_PLAIN
                                                                     : fpet_pkg::mode_t'(cfg.mode);
                    if (cfg.limit == '0)
                    begin
                        res_next   = '0;
                        state_next = fpet_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = fpet_pkg::ST_RR;
                    end
                end
            end
            fpet_pkg::ST_RR:
            begin
                rr_next    = prod;
                state_next = fpet_pkg::ST_II;
            end
            fpet_pkg::ST_II:
            begin
                ii_next    = prod;
                state_next = fpet_pkg::ST_X;
            end
            fpet_pkg::ST_X:
            begin
                xx_next = prod;
                wr_next = zr_reg;
                wi_next = zi_reg;
                k_next  = fpet_pkg::POW_BITS'(1);
                if (mag_sum > fpet_pkg::ESCAPE_LIMIT)
                begin
                    res_next   = i_reg;
                    state_next = fpet_pkg::ST_DONE;
                end
                else if (mode_reg == fpet_pkg::MODE_MULTI)
                begin
                    state_next = (power_reg > fpet_pkg::POW_BITS'(1)) ? fpet_pkg::ST_M1
                                                                      : fpet_pkg::ST_UPD;
                end
                else if (mode_reg == fpet_pkg::MODE_PHOENIX)
                begin
                    state_next = fpet_pkg::ST_P1;
                end
                else
                begin
                    state_next = fpet_pkg::ST_UPD;
                end
            end
            fpet_pkg::ST_M1:
            begin
                ta_next    = prod;
                state_next = fpet_pkg::ST_M2;
            end
            fpet_pkg::ST_M2:
            begin
                tb_next    = prod;
                state_next = fpet_pkg::ST_M3;
            end
            fpet_pkg::ST_M3:
            begin
                tc_next    = prod;
                state_next = fpet_pkg::ST_M4;
            end
            fpet_pkg::ST_M4:
            begin
                wr_next    = ta_reg - tb_reg;
                wi_next    = tc_reg + prod;
                k_next     = k_inc[fpet_pkg::POW_BITS-1:0];
                state_next = (k_inc < {1'b0, power_reg}) ? fpet_pkg::ST_M1 : fpet_pkg::ST_UPD;
            end
            fpet_pkg::ST_P1:
            begin
                ta_next    = prod;
                state_next = fpet_pkg::ST_P2;
            end
            fpet_pkg::ST_P2:
            begin
                tb_next    = prod;
                state_next = fpet_pkg::ST_UPD;
            end
            fpet_pkg::ST_UPD:
            begin
                unique case (mode_reg)
                    fpet_pkg::MODE_MULTI:
                    begin
                        zr_next = wr_reg + cr_reg;
                        zi_next = wi_reg + ci_reg;
                    end
                    fpet_pkg::MODE_PHOENIX:
                    begin
                        zr_next = nr + ta_reg;
                        zi_next = ni + tb_reg;
                        pr_next = zr_reg;
                        pi_next = zi_reg;
                    end
                    default:
                    begin
                        zr_next = nr;
                        zi_next = ni;
                    end
                endcase
                state_next = fpet_pkg::ST_CYC;
            end
            fpet_pkg::ST_CYC:
            begin
                if (match)
                begin
                    res_next   = limit_reg;
                    state_next = fpet_pkg::ST_DONE;
                end
                else
                begin
                    i_next = i_inc[fpet_pkg::CNT_BITS-1:0];
                    if (i_inc == save_reg)
                    begin
                        sr_next   = zr_reg;
                        si_next   = zi_reg;
                        spr_next  = pr_reg;
                        spi_next  = pi_reg;
                        save_next = save_reg << 1;
                    end
                    if (i_inc == {1'b0, limit_reg})
                    begin
                        res_next   = limit_reg;
                        state_next = fpet_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = fpet_pkg::ST_RR;
                    end
                end
            end
            fpet_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fpet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpet_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpet_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        pr_reg    <= pr_next;
        pi_reg    <= pi_next;
        sr_reg    <= sr_next;
        si_reg    <= si_next;
        spr_reg   <= spr_next;
        spi_reg   <= spi_next;
        rr_reg    <= rr_next;
        ii_reg    <= ii_next;
        xx_reg    <= xx_next;
        wr_reg    <= wr_next;
        wi_reg    <= wi_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        tc_reg    <= tc_next;
        i_reg     <= i_next;
        limit_reg <= limit_next;
        res_reg   <= res_next;
        save_reg  <= save_next;
        k_reg     <= k_next;
        power_reg <= power_next;
    end

    assign busy         = (state_reg != fpet_pkg::ST_IDLE);
    assign result.done  = (state_reg == fpet_pkg::ST_DONE);
    assign result.count = res_reg;

endmodule

// ===== design/fixed_point_escape_time_iterator.sv =====
// ---------------------------------------------------------------------------
// fixed_point_escape_time_iterator
// escape time count of one point in signed 16.16 fixed point
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  start_re, start_im, const_re, const_im
// out       output     out_valid/out_stall iteration_count
// cfg       input      cfg_we             cfg_index, cfg_data
//
// one shared 32x32 multiplier sets the pace: an iteration runs RR, II, X,
// UPD and CYC, phoenix mode adds P1 and P2, multibrot mode with power 2 or
// more adds M1 to M4 per power above 1; an escaping iteration ends after X.
// reset clears the sequencer, the output valid and the config registers.
// in_stall stays high from acceptance until the result moves to the output
// register; a waiting result there does not block the next one.
// ---------------------------------------------------------------------------
module fixed_point_escape_time_iterator
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [fpet_pkg::IN_BITS-1:0]    start_re,
    input  logic signed [fpet_pkg::IN_BITS-1:0]    start_im,
    input  logic signed [fpet_pkg::IN_BITS-1:0]    const_re,
    input  logic signed [fpet_pkg::IN_BITS-1:0]    const_im,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [fpet_pkg::CNT_BITS-1:0]          iteration_count,
    input  logic                                   cfg_we,
    input  logic [fpet_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [fpet_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    fpet_pkg::cfg_t    cfg_reg;
    fpet_pkg::result_t result;
    logic              busy;
    logic              out_free;
    logic              out_valid_reg;
    logic [fpet_pkg::CNT_BITS-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode  <= fpet_pkg::MODE_RESET;
            cfg_reg.limit <= fpet_pkg::LIMIT_RESET;
            cfg_reg.power <= fpet_pkg::POWER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fpet_pkg::REG_MODE:
                begin
                    cfg_reg.mode <= cfg_data[fpet_pkg::MODE_BITS-1:0];
                end
                fpet_pkg::REG_LIMIT:
                begin
                    cfg_reg.limit <= cfg_data[fpet_pkg::CNT_BITS-1:0];
                end
                fpet_pkg::REG_POWER:
                begin
                    cfg_reg.power <= cfg_data[fpet_pkg::POW_BITS-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign in_stall = busy;
    assign out_free = !out_valid_reg || !out_stall;

    fpet_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid && !busy),
        .start_re (start_re),
        .start_im (start_im),
        .const_re (const_re),
        .const_im (const_im),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .busy     (busy),
        .result   (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.done && out_free)
        begin
            count_reg <= result.count;
        end
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = count_reg;

endmodule

// ===== design/fpet_checker.sv =====
// ---------------------------------------------------------------------------
// fpet_checker
// port level checks of the escape time iterator
// ---------------------------------------------------------------------------
`include "fixed_point_escape_time_iterator_defines.svh"

module fpet_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [fpet_pkg::CNT_BITS-1:0] iteration_count
);

    // busy right after a transaction is taken
`FPET_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after accept")

    // no result can appear the cycle after a transaction is taken
`FPET_ASSERT_NEXT(a_min_latency, clk, rst_n, in_valid && !in_stall, !$rose(out_valid), "result too early")

    // a new result leaves the block free for the next transaction
`FPET_ASSERT_IMPLIES(a_free_on_result, clk, rst_n, $rose(out_valid), !in_stall, "busy with result out")

    // stalled result holds
`FPET_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(iteration_count), "stalled result changed")

endmodule

bind fixed_point_escape_time_iterator fpet_checker u_fpet_checker (.*);
